// ===== sv/gwm_pkg.sv =====
// Shared types, character codes and item kinds for the glob wildcard matcher.
// No dependencies; imported by every module of the block.
package gwm_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_VALUE  = 2'd2;
    localparam logic [1:0] MODE_END    = 2'd3;

    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    typedef struct packed {
        logic clear;
        logic append;
    } gwm_store_cmd_t;

    // Fold ASCII upper case onto lower case.
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

// ===== sv/glob_wildcard_matcher_unit.sv =====
// Glob wildcard matcher top level: input register, vector update, result register.
// Depends on gwm_pkg, gwm_pattern_store and gwm_closure.
//
// Takes one beat per clock: clear pattern, append pattern byte, value byte or end of value
// (s_tuser). The pattern ('*' any run, '?' one byte, letters case-insensitive) sits in a
// PATTERN_MAX-entry register store; each value byte moves a (PATTERN_MAX+1)-bit vector of
// reachable positions through a log-depth star-closure scan and per-entry compares, so the
// sustained rate is one beat per cycle. An end-of-value beat yields one result beat on
// m_tvalid, passing through the input register and then the result register;
// other beats yield none. A full result register that is not taken stalls only
// end-of-value beats.
module glob_wildcard_matcher_unit #(
    parameter int PATTERN_MAX = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import gwm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int VEC_W = PATTERN_MAX + 1;

    logic                   in_valid_reg;
    logic [1:0]             mode_reg;
    logic [7:0]             char_reg;
    logic                   proc;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   matched_reg;
    logic                   ovf_out_reg;

    logic [VEC_W-1:0]       reach_reg;
    logic [VEC_W-1:0]       reach_next;
    logic [VEC_W-1:0]       closed;
    logic [VEC_W-1:0]       adv_vec;

    gwm_store_cmd_t         cmd;
    logic [LEN_W-1:0]       length;
    logic                   overflow;
    logic [PATTERN_MAX-1:0] star;
    logic [PATTERN_MAX-1:0] question;
    logic [7:0]             pat_char [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] advance;
    logic [7:0]             value_folded;
    logic                   match_bit;

    // an end-of-value beat waits for room in the result register
    assign proc     = in_valid_reg && ((mode_reg != MODE_END) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            mode_reg <= s_tuser;
            char_reg <= s_tdata;
        end
    end

    assign cmd.clear  = proc && (mode_reg == MODE_CLEAR);
    assign cmd.append = proc && (mode_reg == MODE_APPEND);

    gwm_pattern_store #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_byte (char_reg),
        .length    (length),
        .overflow  (overflow),
        .star      (star),
        .question  (question),
        .pat_char  (pat_char)
    );

    gwm_closure #(
        .WIDTH (VEC_W)
    ) u_closure (
        .reach  (reach_reg),
        .link   (star),
        .closed (closed)
    );

    assign value_folded = fold_byte(char_reg);

    genvar i;
    generate
        for (i = 0; i < PATTERN_MAX; i++)
        begin : g_adv
            // only entries below the current length take part
            assign advance[i] = closed[i] && (LEN_W'(i) < length) && !star[i]
                              && (question[i] || (pat_char[i] == value_folded));
        end
    endgenerate

    // stars hold their position; other entries step one place on
    assign adv_vec = {advance, 1'b0} | {1'b0, closed[PATTERN_MAX-1:0] & star};

    assign match_bit = closed[length] && !overflow;

    always_comb
    begin
        reach_next = reach_reg;
        if (proc)
        begin
            case (mode_reg)
                MODE_CLEAR, MODE_END:
                begin
                    reach_next = VEC_W'(1);
                end
                MODE_VALUE:
                begin
                    reach_next = adv_vec;
                end
                default:
                begin
                    reach_next = reach_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= VEC_W'(1);
        end
        else
        begin
            reach_reg <= reach_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (proc && (mode_reg == MODE_END))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && (mode_reg == MODE_END))
        begin
            matched_reg <= match_bit;
            ovf_out_reg <= overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, ovf_out_reg, matched_reg};

endmodule

// ===== sv/gwm_pattern_store.sv =====
// Pattern store: folded pattern bytes, per-entry valid bits, length and overflow flag.
// Depends on gwm_pkg.
module gwm_pattern_store #(
    parameter int PATTERN_MAX = 32,
    parameter int LEN_W       = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gwm_pkg::gwm_store_cmd_t cmd,
    input  logic [7:0]            char_byte,
    output logic [LEN_W-1:0]      length,
    output logic                  overflow,
    output logic [PATTERN_MAX-1:0] star,
    output logic [PATTERN_MAX-1:0] question,
    output logic [7:0]            pat_char [PATTERN_MAX]
);
    import gwm_pkg::*;

    logic [7:0]             entry_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] valid_reg;
    logic [PATTERN_MAX-1:0] valid_next;
    logic [PATTERN_MAX-1:0] wr_en;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   full;

    assign full = (len_reg == LEN_W'(PATTERN_MAX));

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        valid_next = valid_reg | wr_en;
        if (cmd.clear)
        begin
            len_next   = '0;
            ovf_next   = 1'b0;
            valid_next = '0;
        end
        else if (cmd.append)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < PATTERN_MAX; i++)
        begin : g_entry
            assign wr_en[i] = cmd.append && !cmd.clear && (len_reg == LEN_W'(i));

            always_ff @(posedge clk)
            begin
                if (wr_en[i])
                begin
                    entry_reg[i] <= fold_byte(char_byte);
                end
            end

            assign star[i]     = valid_reg[i] && (entry_reg[i] == CH_STAR);
            assign question[i] = valid_reg[i] && (entry_reg[i] == CH_QUESTION);
            assign pat_char[i] = entry_reg[i];
        end
    endgenerate

    assign length   = len_reg;
    assign overflow = ovf_reg;

endmodule

// ===== sv/gwm_closure.sv =====
// Star closure of the reachable-position vector as a log-depth prefix scan.
// Depends on gwm_pkg.
module gwm_closure #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] reach,
    input  logic [WIDTH-2:0] link,   // link[j]: entry j is a star, carry j to j+1
    output logic [WIDTH-1:0] closed
);
    import gwm_pkg::*;

    localparam int LEVELS = $clog2(WIDTH);

    logic [WIDTH-1:0] g_lvl [LEVELS+1];
    logic [WIDTH-1:0] p_lvl [LEVELS+1];

    assign g_lvl[0] = reach;
    assign p_lvl[0] = {link, 1'b0};

    genvar l, j;
    generate
        for (l = 0; l < LEVELS; l++)
        begin : g_level
            for (j = 0; j < WIDTH; j++)
            begin : g_bit
                if (j >= (1 << l))
                begin : g_comb
                    assign g_lvl[l+1][j] = g_lvl[l][j]
                                         | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
                    assign p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
                end
                else
                begin : g_pass
                    assign g_lvl[l+1][j] = g_lvl[l][j];
                    assign p_lvl[l+1][j] = 1'b0;
                end
            end
        end
    endgenerate

    assign closed = g_lvl[LEVELS];

endmodule
